### sv/address_to_line_table_search_defines.svh
// assertion macros for the address-to-line table search
`ifndef ADDRESS_TO_LINE_TABLE_SEARCH_DEFINES_SVH
`define ADDRESS_TO_LINE_TABLE_SEARCH_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define ATL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ATL_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ATL_ASSERT(lbl, clk, rst_n, prop, msg)
`define ATL_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### sv/atl_pkg.sv
`default_nettype none
package atl_pkg;

  localparam int unsigned DEPTH_DEFAULT = 4096;

  localparam int unsigned OP_W       = 2;
  localparam int unsigned IDX_FIELD_W = 12;
  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned LINE_W     = 16;
  localparam int unsigned COUNT_W    = 13;
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 80;

  typedef enum logic [OP_W-1:0] {
    OP_LOAD  = 2'd0,
    OP_NEAR  = 2'd1,
    OP_EXACT = 2'd2,
    OP_NEXT  = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_A0,
    S_AL,
    S_SRCH,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [LINE_W-1:0] line;
    logic [ADDR_W-1:0] addr;
  } entry_t;

  localparam int unsigned ENTRY_W = $bits(entry_t);

endpackage
`default_nettype wire

### sv/atl_ram.sv
`default_nettype none
module atl_ram #(
  parameter int unsigned WIDTH = atl_pkg::ENTRY_W,
  parameter int unsigned DEPTH = atl_pkg::DEPTH_DEFAULT,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

### sv/address_to_line_table_search.sv
`default_nettype none
// Address-to-line table search over a sorted table of (address, line) entries.
// Input stream: tuser carries the operation (load, nearest below, exact, next
// address), tdata the slot, the address and the line. Every item produces one
// result item on the output stream (line, offset, next address).
// Configuration: cfg_we_i/cfg_wdata_i write entry_count; the user must write it
// only while idle, the block itself does not enforce this. A load item writes
// its slot in the accept cycle and then goes to the done state. A query on an
// empty table skips the search and takes the same path as a load. Any other
// query reads the first and the last used entry, then runs a binary search
// with one table read per cycle through the single read port of the entry
// memory: at most ceil(log2(n+1)) search reads, n the used entry count. Such a
// query passes the first-entry, last-entry, search and done states in order.
// One item is in work at a time.
// The result sits in an output register, so the next item is accepted while a
// result still waits; a stalled receiver holds a finished result in the done
// state until the output register frees up.
// Reset clears the count, control and output valid; the table contents stay
// undefined until loaded and no clearing pass runs.
`include "address_to_line_table_search_defines.svh"
module address_to_line_table_search #(
  parameter int unsigned DEPTH = atl_pkg::DEPTH_DEFAULT
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 cfg_we_i,
  input  wire logic [atl_pkg::COUNT_W-1:0]          cfg_wdata_i,
  input  wire logic                                 s_axis_tvalid,
  output logic                                      s_axis_tready,
  // [11:0] entry_index, [43:12] address, [59:44] entry_line, [63:60] zero
  input  wire logic [atl_pkg::IN_DATA_W-1:0]        s_axis_tdata,
  // [1:0] operation
  input  wire logic [atl_pkg::OP_W-1:0]             s_axis_tuser,
  output logic                                      m_axis_tvalid,
  input  wire logic                                 m_axis_tready,
  // [15:0] line, [47:16] offset, [79:48] next_address
  output logic [atl_pkg::OUT_DATA_W-1:0]            m_axis_tdata
);

  localparam int unsigned IDX_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  atl_pkg::state_e state_q, state_d;
  atl_pkg::op_e    op_q, op_d, in_op;

  logic [atl_pkg::COUNT_W-1:0]    count_q;
  logic [atl_pkg::ADDR_W-1:0]     q_q, q_d, a0_q, a0_d, alast_q, alast_d;
  logic [atl_pkg::ADDR_W-1:0]     rec_addr_q, rec_addr_d;
  logic [atl_pkg::LINE_W-1:0]     rec_line_q, rec_line_d;
  logic                           found_q, found_d;
  logic [CNT_W-1:0]               n_q, n_d, lo_q, lo_d, hi_q, hi_d;
  logic [IDX_W-1:0]               mid_q, mid_d;
  logic                           out_valid_q, out_valid_d;
  logic [atl_pkg::OUT_DATA_W-1:0] out_data_q, out_data_d;

  logic [atl_pkg::IDX_FIELD_W-1:0] in_idx;
  logic [atl_pkg::ADDR_W-1:0]      in_addr;
  logic [atl_pkg::LINE_W-1:0]      in_line;
  logic [31:0]                     idx32, cnt32;
  logic                            accept, go_right, take;
  logic [CNT_W-1:0]                lo_n, hi_n, mid_w, nm1, half_n;
  logic [atl_pkg::LINE_W-1:0]      res_line;
  logic [atl_pkg::ADDR_W-1:0]      res_off, res_next;

  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr, ram_raddr;
  atl_pkg::entry_t      ram_wdata, ram_rdata;

  atl_ram #(
    .WIDTH (atl_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (1'b1),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_op   = atl_pkg::op_e'(s_axis_tuser);
  assign in_idx  = s_axis_tdata[11:0];
  assign in_addr = s_axis_tdata[43:12];
  assign in_line = s_axis_tdata[59:44];
  assign idx32   = {20'd0, in_idx};
  assign cnt32   = {19'd0, count_q};

  assign s_axis_tready = (state_q == atl_pkg::S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  assign ram_waddr      = idx32[IDX_W-1:0];
  assign ram_wdata.addr = in_addr;
  assign ram_wdata.line = in_line;

  // result from the record of the last entry that moved the bound
  always_comb begin
    res_line = '0;
    res_off  = '0;
    res_next = '0;
    unique case (op_q)
      atl_pkg::OP_LOAD: begin
      end
      atl_pkg::OP_NEAR: begin
        if (found_q && (q_q >= a0_q)) begin
          res_line = rec_line_q;
          if (q_q <= alast_q) begin
            res_off = q_q - rec_addr_q;
          end
        end
      end
      atl_pkg::OP_EXACT: begin
        if (found_q && (q_q >= a0_q) && (rec_addr_q == q_q)) begin
          res_line = rec_line_q;
        end
      end
      atl_pkg::OP_NEXT: begin
        res_next = (found_q && (q_q <= alast_q)) ? rec_addr_q : q_q;
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    q_d         = q_q;
    n_d         = n_q;
    a0_d        = a0_q;
    alast_d     = alast_q;
    found_d     = found_q;
    rec_addr_d  = rec_addr_q;
    rec_line_d  = rec_line_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    ram_we      = 1'b0;
    ram_raddr   = '0;

    // floor search moves right on a <= q, ceiling search on a < q
    go_right = (op_q == atl_pkg::OP_NEXT) ? (ram_rdata.addr < q_q)
                                          : (ram_rdata.addr <= q_q);
    take     = (op_q == atl_pkg::OP_NEXT) ? !go_right : go_right;
    lo_n     = go_right ? (CNT_W'(mid_q) + CNT_W'(1)) : lo_q;
    hi_n     = go_right ? hi_q : CNT_W'(mid_q);
    mid_w    = lo_n + ((hi_n - lo_n) >> 1);
    nm1      = n_q - CNT_W'(1);
    half_n   = n_q >> 1;

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      atl_pkg::S_IDLE: begin
        if (accept) begin
          op_d    = in_op;
          q_d     = in_addr;
          found_d = 1'b0;
          n_d     = (cnt32 > DEPTH) ? CNT_W'(DEPTH) : cnt32[CNT_W-1:0];
          if (in_op == atl_pkg::OP_LOAD) begin
            ram_we  = (idx32 < DEPTH);
            state_d = atl_pkg::S_DONE;
          end else if (n_d == '0) begin
            state_d = atl_pkg::S_DONE;
          end else begin
            state_d = atl_pkg::S_A0;
          end
        end
      end
      atl_pkg::S_A0: begin
        a0_d      = ram_rdata.addr;
        ram_raddr = nm1[IDX_W-1:0];
        state_d   = atl_pkg::S_AL;
      end
      atl_pkg::S_AL: begin
        alast_d   = ram_rdata.addr;
        lo_d      = '0;
        hi_d      = n_q;
        mid_d     = half_n[IDX_W-1:0];
        ram_raddr = half_n[IDX_W-1:0];
        state_d   = atl_pkg::S_SRCH;
      end
      atl_pkg::S_SRCH: begin
        if (take) begin
          found_d    = 1'b1;
          rec_addr_d = ram_rdata.addr;
          rec_line_d = ram_rdata.line;
        end
        lo_d = lo_n;
        hi_d = hi_n;
        if (lo_n < hi_n) begin
          mid_d     = mid_w[IDX_W-1:0];
          ram_raddr = mid_w[IDX_W-1:0];
        end else begin
          state_d = atl_pkg::S_DONE;
        end
      end
      atl_pkg::S_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          out_data_d  = {res_next, res_off, res_line};
          out_valid_d = 1'b1;
          state_d     = atl_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = atl_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= atl_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    q_q        <= q_d;
    n_q        <= n_d;
    a0_q       <= a0_d;
    alast_q    <= alast_d;
    found_q    <= found_d;
    rec_addr_q <= rec_addr_d;
    rec_line_q <= rec_line_d;
    lo_q       <= lo_d;
    hi_q       <= hi_d;
    mid_q      <= mid_d;
    out_data_q <= out_data_d;
  end

  `ATL_ASSERT_ALWAYS(a_no_valid_in_reset, clk_i,
    !rst_ni |=> !m_axis_tvalid, "valid during reset")
  `ATL_ASSERT(a_accept_leaves_idle, clk_i, rst_ni,
    accept |=> (state_q != atl_pkg::S_IDLE), "accepted item did not start")
  `ATL_ASSERT(a_mid_in_window, clk_i, rst_ni,
    (state_q == atl_pkg::S_SRCH) |->
      ((lo_q <= CNT_W'(mid_q)) && (CNT_W'(mid_q) < hi_q) && (hi_q <= n_q)),
    "search index outside window")
  `ATL_ASSERT(a_done_fills_output, clk_i, rst_ni,
    ((state_q == atl_pkg::S_DONE) && (!out_valid_q || m_axis_tready)) |=> out_valid_q,
    "finished result not presented")

endmodule
`default_nettype wire
